/* rtl/bml_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bml_pkg: shared types and constants of the bilinear map lookup
// Item modes, field widths, the value range and the sequencer states.
// ----------------------------------------------------------------------------
package bml_pkg;

    localparam int XW      = 15;
    localparam int YW      = 8;
    localparam int CELL_W  = 8;
    localparam int VAL_W   = 9;
    localparam int IDX_W   = 4;
    localparam int DEF_COLS = 16;
    localparam int DEF_ROWS = 16;

    localparam logic [1:0] MODE_CELL  = 2'd0;
    localparam logic [1:0] MODE_XAXIS = 2'd1;
    localparam logic [1:0] MODE_YAXIS = 2'd2;
    localparam logic [1:0] MODE_LOOK  = 2'd3;

    localparam logic signed [VAL_W-1:0] VALUE_MIN = -9'sd128;
    localparam logic signed [VAL_W-1:0] VALUE_MAX = 9'sd255;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_XSCAN,
        ST_YSCAN,
        ST_CELL,
        ST_CWAIT,
        ST_DIV,
        ST_OUT
    } bml_state_t;

    // request to the divider and its answer
    typedef struct packed {
        logic                     start;
        logic signed [XW:0]       dx;    // x - x1
        logic signed [XW:0]       span;  // x2 - x1
        logic signed [VAL_W-1:0]  y1;
        logic signed [VAL_W-1:0]  y2;
    } bml_div_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [VAL_W-1:0]  res;
    } bml_div_rsp_t;

endpackage

`default_nettype wire

/* rtl/bml_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bml_ram: generic single-port synchronous RAM
// One access a cycle, a write also reading the old entry; read data registered.
// ----------------------------------------------------------------------------
module bml_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write the addressed entry when enabled, and read it every cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

/* rtl/bml_interp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bml_interp: one linear interpolation step
// Computes y1 + (dx*(y2-y1))/span truncated toward zero, saturated to the
// value range, by restoring division one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bml_interp
    import bml_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire bml_div_req_t req,
    output bml_div_rsp_t      rsp
);

    // |dx| < 2^15, |y2-y1| < 2^9: product magnitude below 2^25
    localparam int PW = 26;
    localparam int CW = $clog2(PW + 1);

    logic              busy_reg;
    logic [CW-1:0]     cnt_reg;
    logic [PW-1:0]     num_reg;
    logic [PW-1:0]     rem_reg;
    logic [XW:0]       den_reg;
    logic              neg_reg;
    logic              zero_reg;
    logic signed [VAL_W-1:0] y1_reg;
    logic signed [VAL_W-1:0] res_reg;
    logic              done_reg;
    logic              fin_reg;

    logic signed [PW-1:0]  prod;
    logic signed [VAL_W:0] dy;
    logic [PW-1:0]         rem_sh;
    logic [PW:0]           trial;
    logic signed [PW+1:0]  sum;
    logic [XW:0]           span_abs;

    assign dy       = {req.y2[VAL_W-1], req.y2} - {req.y1[VAL_W-1], req.y1};
    assign prod     = PW'(req.dx) * PW'(dy);
    assign span_abs = req.span[XW] ? (XW+1)'(-req.span) : req.span;
    assign rem_sh   = {rem_reg[PW-2:0], num_reg[PW-1]};
    assign trial    = {1'b0, rem_sh} - {(PW-XW)'(0), den_reg};

    // apply sign to quotient and add y1
    assign sum = (neg_reg ? -$signed({2'b00, num_reg}) : $signed({2'b00, num_reg}))
                 + (PW+2)'(y1_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            fin_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            fin_reg  <= 1'b0;
            if (req.start)
            begin
                busy_reg <= (req.span != '0);
                fin_reg  <= (req.span == '0);
                cnt_reg  <= CW'(PW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
            if (fin_reg)
            begin
                done_reg <= 1'b1;
            end
        end
    end

    // load operands, then shift one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg  <= prod[PW-1] ? PW'(-prod) : prod;
            neg_reg  <= prod[PW-1] ^ req.span[XW];
            den_reg  <= span_abs;
            rem_reg  <= '0;
            zero_reg <= (req.span == '0);
            y1_reg   <= req.y1;
        end
        else if (busy_reg)
        begin
            if (!trial[PW])
            begin
                rem_reg <= trial[PW-1:0];
                num_reg <= {num_reg[PW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                num_reg <= {num_reg[PW-2:0], 1'b0};
            end
        end
        else if (fin_reg)
        begin
            if (zero_reg)
                res_reg <= y1_reg;
            else if (sum < (PW+2)'(VALUE_MIN))
                res_reg <= VALUE_MIN;
            else if (sum > (PW+2)'(VALUE_MAX))
                res_reg <= VALUE_MAX;
            else
                res_reg <= sum[VAL_W-1:0];
        end
    end

    assign rsp = {done_reg, res_reg};

endmodule

`default_nettype wire

/* rtl/bilinear_map_lookup.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bilinear_map_lookup: 2-D calibration map with bilinear interpolation
// Cell grid and both axes live in single-port RAMs; a sequencer scans the
// axes, reads four cells and runs up to three interpolation steps.
// ----------------------------------------------------------------------------
// Write items give no result. A lookup scans the X axis
// (COLS reads) and the Y axis (ROWS reads) one entry a cycle through the
// axis RAM ports, reads four cells from the cell RAM, then runs up to
// three interpolation steps on one shared restoring divider. The next
// item can be taken in the same cycle in which the result is first
// offered. One item is in work at a time; while a finished result waits
// in the output register, writes are still taken but a lookup is held.
// Cells read as signed bytes when cells_signed is set.
module bilinear_map_lookup
    import bml_pkg::*;
#(
    parameter int COLS = DEF_COLS,
    parameter int ROWS = DEF_ROWS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data,      // cells_signed
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [1:0] mode, [5:2] row, [9:6] col, [24:10] write_data,
    // [39:25] query_x, [47:40] query_y
    input  wire logic [47:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata        // [8:0] value
);

    localparam int CA = $clog2(COLS);
    localparam int RA = $clog2(ROWS);
    localparam int MA = RA + CA;

    logic [1:0]      in_mode;
    logic [IDX_W-1:0] in_row, in_col;
    logic [XW-1:0]   in_wd, in_qx;
    logic [YW-1:0]   in_qy;
    assign in_mode = s_tdata[1:0];
    assign in_row  = s_tdata[5:2];
    assign in_col  = s_tdata[9:6];
    assign in_wd   = s_tdata[24:10];
    assign in_qx   = s_tdata[39:25];
    assign in_qy   = s_tdata[47:40];

    bml_state_t state_reg, state_next;
    logic       sgn_reg;
    logic [XW-1:0] qx_reg;
    logic [YW-1:0] qy_reg;
    logic [CA:0]   xi_reg, xi_next;   // scan counter, reaches COLS
    logic [RA:0]   yi_reg, yi_next;
    logic [CA-1:0] xl_reg, xh_reg;
    logic [RA-1:0] yl_reg, yh_reg;
    logic          xf_reg, yf_reg;    // bracket found
    logic [XW-1:0] xprev_reg, x1_reg, x2_reg;
    logic [YW-1:0] yprev_reg, y1_reg, y2_reg;
    logic [2:0]    ci_reg;            // cell read / step index
    logic signed [VAL_W-1:0] q_reg [4];
    logic signed [VAL_W-1:0] r1_reg;
    logic          out_v_reg;
    logic [VAL_W-1:0] out_reg;

    logic            xa_we, ya_we, cs_we;
    logic [CA-1:0]   xa_addr;
    logic [RA-1:0]   ya_addr;
    logic [MA-1:0]   cs_addr;
    logic [XW-1:0]   xa_rd;
    logic [YW-1:0]   ya_rd;
    logic [CELL_W-1:0] cs_rd;
    logic            accept;
    logic            is_look;
    bml_div_req_t    dreq;
    bml_div_rsp_t    drsp;

    assign accept  = s_tvalid && s_tready;
    assign is_look = (in_mode == MODE_LOOK);
    assign s_tready = (state_reg == ST_IDLE) && !(out_v_reg && !m_tready && is_look);
    assign cfg_ready = 1'b1;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sgn_reg <= 1'b0;
        else if (cfg_valid)
            sgn_reg <= cfg_data;
    end

    // memory ports: writes from the item, reads from the sequencer
    assign xa_we = accept && in_mode == MODE_XAXIS && 32'(in_col) < COLS;
    assign ya_we = accept && in_mode == MODE_YAXIS && 32'(in_row) < ROWS;
    assign cs_we = accept && in_mode == MODE_CELL
                   && 32'(in_row) < ROWS && 32'(in_col) < COLS;

    always_comb
    begin
        // a lookup starts its X scan at entry 0
        xa_addr = (state_reg == ST_IDLE && !is_look) ? CA'(in_col) : xi_next[CA-1:0];
        ya_addr = (state_reg == ST_IDLE) ? RA'(in_row) : yi_next[RA-1:0];
        if (state_reg == ST_IDLE)
            cs_addr = {RA'(in_row), CA'(in_col)};
        else
        begin
            case (ci_reg[1:0])
                2'd0:    cs_addr = {yl_reg, xl_reg};
                2'd1:    cs_addr = {yl_reg, xh_reg};
                2'd2:    cs_addr = {yh_reg, xl_reg};
                default: cs_addr = {yh_reg, xh_reg};
            endcase
        end
    end

    bml_ram #(.WIDTH(XW), .DEPTH(1 << CA)) u_xaxis (
        .clk(clk), .we(xa_we), .addr(xa_addr), .wdata(in_wd), .rdata(xa_rd));
    bml_ram #(.WIDTH(YW), .DEPTH(1 << RA)) u_yaxis (
        .clk(clk), .we(ya_we), .addr(ya_addr), .wdata(in_wd[YW-1:0]),
        .rdata(ya_rd));
    bml_ram #(.WIDTH(CELL_W), .DEPTH(1 << MA)) u_cells (
        .clk(clk), .we(cs_we), .addr(cs_addr), .wdata(in_wd[CELL_W-1:0]),
        .rdata(cs_rd));

    bml_interp u_interp (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    // steps: 0 = row yl on X (on Y if X clamped), 1 = row yh on X, 2 = on Y
    logic x_edge, y_edge;
    assign x_edge = (xl_reg == xh_reg);
    assign y_edge = (yl_reg == yh_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        xi_next    = xi_reg;
        yi_next    = yi_reg;
        dreq       = '0;
        case (state_reg)
            ST_IDLE:
            begin
                xi_next = '0;
                yi_next = '0;
                if (accept && is_look)
                    state_next = ST_XSCAN;
            end
            ST_XSCAN:
            begin
                xi_next = xi_reg + 1'b1;
                if (xi_reg == (CA+1)'(COLS - 1))
                    state_next = ST_YSCAN;
            end
            ST_YSCAN:
            begin
                yi_next = yi_reg + 1'b1;
                if (yi_reg == (RA+1)'(ROWS - 1))
                    state_next = ST_CELL;
            end
            ST_CELL:
            begin
                state_next = ST_CWAIT;
            end
            ST_CWAIT:
            begin
                if (ci_reg == 3'd4)
                begin
                    if (x_edge && y_edge)
                        state_next = ST_OUT;
                    else
                    begin
                        state_next = ST_DIV;
                        dreq.start = 1'b1;
                        if (x_edge)
                        begin
                            dreq.dx   = (XW+1)'(qy_reg) - (XW+1)'(y1_reg);
                            dreq.span = (XW+1)'(y2_reg) - (XW+1)'(y1_reg);
                            dreq.y1   = q_reg[0];
                            dreq.y2   = q_reg[2];
                        end
                        else
                        begin
                            dreq.dx   = (XW+1)'(qx_reg) - (XW+1)'(x1_reg);
                            dreq.span = (XW+1)'(x2_reg) - (XW+1)'(x1_reg);
                            dreq.y1   = q_reg[0];
                            dreq.y2   = q_reg[1];
                        end
                    end
                end
                else
                    state_next = ST_CELL;
            end
            ST_DIV:
            begin
                if (drsp.done)
                begin
                    if (x_edge || y_edge || ci_reg == 3'd6)
                        state_next = ST_OUT;
                    else
                    begin
                        dreq.start = 1'b1;
                        if (ci_reg == 3'd4)
                        begin
                            dreq.dx   = (XW+1)'(qx_reg) - (XW+1)'(x1_reg);
                            dreq.span = (XW+1)'(x2_reg) - (XW+1)'(x1_reg);
                            dreq.y1   = q_reg[2];
                            dreq.y2   = q_reg[3];
                        end
                        else
                        begin
                            dreq.dx   = (XW+1)'(qy_reg) - (XW+1)'(y1_reg);
                            dreq.span = (XW+1)'(y2_reg) - (XW+1)'(y1_reg);
                            dreq.y1   = r1_reg;
                            dreq.y2   = drsp.res;
                        end
                    end
                end
            end
            ST_OUT:
            begin
                if (!out_v_reg || m_tready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && (!out_v_reg || m_tready))
                out_v_reg <= 1'b1;
            else if (m_tready)
                out_v_reg <= 1'b0;
        end
    end

    // search, cell fetch and result datapath
    always_ff @(posedge clk)
    begin
        xi_reg <= xi_next;
        yi_reg <= yi_next;
        case (state_reg)
            ST_IDLE:
            begin
                qx_reg <= in_qx;
                qy_reg <= in_qy;
                xf_reg <= 1'b0;
                yf_reg <= 1'b0;
                ci_reg <= '0;
            end
            ST_XSCAN:
            begin
                // xa_rd holds entry xi_reg
                xprev_reg <= xa_rd;
                if (xi_reg == '0)
                begin
                    if (qx_reg <= xa_rd)
                    begin
                        xl_reg <= '0; xh_reg <= '0; xf_reg <= 1'b1;
                        x1_reg <= xa_rd; x2_reg <= xa_rd;
                    end
                end
                else if (xi_reg == (CA+1)'(COLS - 1) && qx_reg >= xa_rd
                         && !(xf_reg && xl_reg == xh_reg))
                begin
                    // clamp high over any bracket, unless clamped low
                    xl_reg <= xi_reg[CA-1:0]; xh_reg <= xi_reg[CA-1:0];
                    x1_reg <= xa_rd; x2_reg <= xa_rd;
                end
                else if (!xf_reg)
                begin
                    if ((qx_reg >= xprev_reg && qx_reg < xa_rd)
                        || xi_reg == (CA+1)'(COLS - 1))
                    begin
                        xl_reg <= CA'(xi_reg - 1'b1); xh_reg <= xi_reg[CA-1:0];
                        x1_reg <= xprev_reg; x2_reg <= xa_rd;
                        xf_reg <= 1'b1;
                    end
                end
            end
            ST_YSCAN:
            begin
                yprev_reg <= ya_rd;
                if (yi_reg == '0)
                begin
                    if (qy_reg <= ya_rd)
                    begin
                        yl_reg <= '0; yh_reg <= '0; yf_reg <= 1'b1;
                        y1_reg <= ya_rd; y2_reg <= ya_rd;
                    end
                end
                else if (yi_reg == (RA+1)'(ROWS - 1) && qy_reg >= ya_rd
                         && !(yf_reg && yl_reg == yh_reg))
                begin
                    // clamp high over any bracket, unless clamped low
                    yl_reg <= yi_reg[RA-1:0]; yh_reg <= yi_reg[RA-1:0];
                    y1_reg <= ya_rd; y2_reg <= ya_rd;
                end
                else if (!yf_reg)
                begin
                    if ((qy_reg >= yprev_reg && qy_reg < ya_rd)
                        || yi_reg == (RA+1)'(ROWS - 1))
                    begin
                        yl_reg <= RA'(yi_reg - 1'b1); yh_reg <= yi_reg[RA-1:0];
                        y1_reg <= yprev_reg; y2_reg <= ya_rd;
                        yf_reg <= 1'b1;
                    end
                end
            end
            ST_CELL:
            begin
                ci_reg <= ci_reg + 1'b1;
            end
            ST_CWAIT:
            begin
                q_reg[ci_reg[1:0] - 2'd1] <= sgn_reg
                    ? VAL_W'($signed(cs_rd)) : VAL_W'({1'b0, cs_rd});
                if (ci_reg == 3'd4)
                    out_reg <= q_reg[0];
            end
            ST_DIV:
            begin
                if (drsp.done)
                begin
                    ci_reg  <= ci_reg + 1'b1;
                    r1_reg  <= drsp.res;
                    out_reg <= drsp.res;
                end
            end
            default:
            begin
            end
        endcase
    end

    // hold the finished value until its transfer
    logic [VAL_W-1:0] m_val_reg;
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT && (!out_v_reg || m_tready))
            m_val_reg <= out_reg;
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {{(16 - VAL_W){1'b0}}, m_val_reg};

    // no item taken outside idle
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> state_reg == ST_IDLE)
        else $error("item taken while busy");
    // a result is only raised from the output state
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg) == ST_OUT)
        else $error("result without lookup");
    // divider answers only during the divide state
    a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
        drsp.done |-> state_reg == ST_DIV)
        else $error("stray divider result");

endmodule

`default_nettype wire

/* bench/bilinear_map_lookup_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_map_lookup_test: self-checking bench for the 2-D map lookup
// Fills the grid and both axes, runs a directed table of clamps, corners,
// broken axes and sign modes, then random phases under varied back-pressure.
// Each lookup value is compared with a behavioral copy of the map or a table value.
// ----------------------------------------------------------------------------
module bilinear_map_lookup_test
    import bml_pkg::*;
();

    localparam int NCOL       = 16;
    localparam int NROW       = 16;
    localparam int DRAIN      = 300;
    localparam int STALL_MAX  = 20000;
    localparam int RAND_ITEMS = 270;

    typedef struct {
        logic              is_cfg;
        logic [1:0]        mode;
        logic [3:0]        row;
        logic [3:0]        col;
        logic [14:0]       wdata;
        logic [14:0]       qx;
        logic [7:0]        qy;
        logic              typed;
        logic signed [8:0] value;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    // behavioral copy of the map contents and register
    logic [7:0]        grid [NROW*NCOL];
    int                x_points [NCOL];
    int                y_points [NROW];
    logic              signed_cells;
    logic signed [8:0] expected_values [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatches     = 0;
    int stall_cycles   = 0;

    bilinear_map_lookup u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // locate the bracketing pair, clamping at both ends
    function automatic void find_pair(input int pts [16], input int q,
                                      output int lo, output int hi);
        lo = 14;
        hi = 15;
        if (q <= pts[0])
        begin
            lo = 0;
            hi = 0;
        end
        else if (q >= pts[15])
        begin
            lo = 15;
            hi = 15;
        end
        else
        begin
            for (int i = 14; i >= 0; i--)
                if (q >= pts[i] && q < pts[i+1])
                begin
                    lo = i;
                    hi = i + 1;
                end
        end
    endfunction

    function automatic longint blend(input longint q, input longint p1, input longint p2,
                                     input longint v1, input longint v2);
        longint r;
        if (p2 == p1)
            return v1;
        r = v1 + ((q - p1) * (v2 - v1)) / (p2 - p1);
        if (r < -128)
            r = -128;
        if (r > 255)
            r = 255;
        return r;
    endfunction

    function automatic longint cell_at(input int r, input int c);
        logic [7:0] b;
        b = grid[r*NCOL + c];
        return signed_cells ? longint'($signed(b)) : longint'(b);
    endfunction

    function automatic logic signed [8:0] map_value(input int qx, input int qy);
        int     xl, xh, yl, yh;
        longint r1, r2, res;
        find_pair(x_points, qx, xl, xh);
        find_pair(y_points, qy, yl, yh);
        if (xl == xh && yl == yh)
            res = cell_at(yl, xl);
        else if (xl == xh)
            res = blend(qy, y_points[yl], y_points[yh], cell_at(yl, xl), cell_at(yh, xl));
        else if (yl == yh)
            res = blend(qx, x_points[xl], x_points[xh], cell_at(yl, xl), cell_at(yl, xh));
        else
        begin
            r1 = blend(qx, x_points[xl], x_points[xh], cell_at(yl, xl), cell_at(yl, xh));
            r2 = blend(qx, x_points[xl], x_points[xh], cell_at(yh, xl), cell_at(yh, xh));
            res = blend(qy, y_points[yl], y_points[yh], r1, r2);
        end
        return res[8:0];
    endfunction

    // drive one item, wait for its transfer, then update the copy
    task automatic send_item(input logic [1:0] mode, input logic [3:0] row,
                             input logic [3:0] col, input logic [14:0] wdata,
                             input logic [14:0] qx, input logic [7:0] qy,
                             input logic typed, input logic signed [8:0] typed_value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {qy, qx, wdata, col, row, mode};
        do
            @(posedge clk);
        while (!s_tready);
        case (mode)
            MODE_CELL:  grid[row*NCOL + col] = wdata[7:0];
            MODE_XAXIS: x_points[col] = wdata;
            MODE_YAXIS: y_points[row] = wdata[7:0];
            default:    expected_values.push_back(typed ? typed_value : map_value(qx, qy));
        endcase
    endtask

    // write the register once the block has gone quiet
    task automatic write_sign_mode(input logic v);
        s_tvalid <= 1'b0;
        while (expected_values.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        signed_cells = v;
    endtask

    // load a fresh strictly ascending pair of axes
    task automatic load_axes();
        int xv, yv;
        xv = $urandom_range(0, 1000);
        yv = $urandom_range(0, 15);
        for (int i = 0; i < 16; i++)
        begin
            send_item(MODE_XAXIS, 4'($urandom), 4'(i), 15'(xv), 15'($urandom),
                      8'($urandom), 1'b0, '0);
            send_item(MODE_YAXIS, 4'(i), 4'($urandom), {7'($urandom), 8'(yv)},
                      15'($urandom), 8'($urandom), 1'b0, '0);
            xv += $urandom_range(1, 2047);
            yv += $urandom_range(1, 15);
            if (xv > 32767)
                xv = 32767;
        end
    endtask

    // one random item: mostly lookups, some cell and axis rewrites
    task automatic random_item();
        int          pick, idx, lo, hi;
        logic [14:0] v;
        pick = $urandom_range(99);
        idx  = $urandom_range(0, 15);
        if (pick < 5)
        begin
            // x entry, usually kept between its neighbors
            lo = (idx == 0) ? 0 : x_points[idx-1] + 1;
            hi = (idx == 15) ? 32767 : x_points[idx+1] - 1;
            v = ($urandom_range(9) < 8 && lo <= hi) ? 15'($urandom_range(hi, lo))
                                                    : 15'($urandom);
            send_item(MODE_XAXIS, 4'($urandom), 4'(idx), v, 15'($urandom),
                      8'($urandom), 1'b0, '0);
        end
        else if (pick < 10)
        begin
            lo = (idx == 0) ? 0 : y_points[idx-1] + 1;
            hi = (idx == 15) ? 255 : y_points[idx+1] - 1;
            v = {7'($urandom), ($urandom_range(9) < 8 && lo <= hi) ?
                 8'($urandom_range(hi, lo)) : 8'($urandom)};
            send_item(MODE_YAXIS, 4'(idx), 4'($urandom), v, 15'($urandom),
                      8'($urandom), 1'b0, '0);
        end
        else if (pick < 30)
            send_item(MODE_CELL, 4'($urandom), 4'($urandom), 15'($urandom),
                      15'($urandom), 8'($urandom), 1'b0, '0);
        else
            send_item(MODE_LOOK, 4'($urandom), 4'($urandom), 15'($urandom),
                      15'($urandom), 8'($urandom), 1'b0, '0);
    endtask

    // directed cases: extremes, clamps, corners, broken axes, sign modes
    stim_row_t directed_rows [] = '{
        '{1'b0, MODE_CELL,  4'd0,  4'd0,  15'h7FFF, 15'd0,     8'd0,   1'b0, 9'sd0},
        '{1'b0, MODE_LOOK,  4'd0,  4'd0,  15'd0,    15'd0,     8'd0,   1'b1, 9'sd255},
        '{1'b0, MODE_CELL,  4'd15, 4'd15, 15'h0080, 15'd0,     8'd0,   1'b0, 9'sd0},
        '{1'b0, MODE_LOOK,  4'd15, 4'd15, 15'h7FFF, 15'h7FFF,  8'hFF,  1'b1, 9'sd128},
        '{1'b0, MODE_XAXIS, 4'd0,  4'd15, 15'h7FFF, 15'd0,     8'd0,   1'b0, 9'sd0},
        '{1'b0, MODE_LOOK,  4'd0,  4'd0,  15'd0,    15'd31000, 8'd100, 1'b0, 9'sd0},
        '{1'b0, MODE_LOOK,  4'd0,  4'd0,  15'd0,    15'd1000,  8'd8,   1'b0, 9'sd0},
        '{1'b0, MODE_LOOK,  4'd0,  4'd0,  15'd0,    15'd0,     8'd100, 1'b0, 9'sd0},
        '{1'b0, MODE_LOOK,  4'd0,  4'd0,  15'd0,    15'd5000,  8'd0,   1'b0, 9'sd0},
        '{1'b0, MODE_XAXIS, 4'd0,  4'd5,  15'd0,    15'd0,     8'd0,   1'b0, 9'sd0},
        '{1'b0, MODE_LOOK,  4'd0,  4'd0,  15'd0,    15'd9000,  8'd40,  1'b0, 9'sd0},
        '{1'b0, MODE_XAXIS, 4'd0,  4'd5,  15'd10000, 15'd0,    8'd0,   1'b0, 9'sd0},
        '{1'b0, MODE_YAXIS, 4'd14, 4'd0,  15'd240,  15'd0,     8'd0,   1'b0, 9'sd0},
        '{1'b0, MODE_LOOK,  4'd0,  4'd0,  15'd0,    15'd7000,  8'd235, 1'b0, 9'sd0},
        '{1'b0, MODE_YAXIS, 4'd7,  4'd0,  15'd250,  15'd0,     8'd0,   1'b0, 9'sd0},
        '{1'b0, MODE_LOOK,  4'd0,  4'd0,  15'd0,    15'd3000,  8'd120, 1'b0, 9'sd0},
        '{1'b0, MODE_YAXIS, 4'd7,  4'd0,  15'd112,  15'd0,     8'd0,   1'b0, 9'sd0},
        '{1'b1, MODE_CELL,  4'd0,  4'd0,  15'd1,    15'd0,     8'd0,   1'b0, 9'sd0},
        '{1'b0, MODE_LOOK,  4'd0,  4'd0,  15'd0,    15'd0,     8'd0,   1'b1, -9'sd1},
        '{1'b0, MODE_LOOK,  4'd0,  4'd0,  15'd0,    15'h7FFF,  8'hFF,  1'b1, -9'sd128},
        '{1'b0, MODE_LOOK,  4'd0,  4'd0,  15'd0,    15'd17000, 8'd77,  1'b0, 9'sd0},
        '{1'b1, MODE_CELL,  4'd0,  4'd0,  15'd0,    15'd0,     8'd0,   1'b0, 9'sd0}
    };

    // check results against the oldest expectation
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            if (expected_values.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: value=%0d", $signed(m_tdata[8:0]));
            end
            else
            begin
                if (m_tdata[8:0] !== expected_values[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("value mismatch: expected=%0d actual=%0d",
                                 expected_values[0], $signed(m_tdata[8:0]));
                end
                void'(expected_values.pop_front());
            end
        end
        if (rst_n)
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // end the run if no transfer happens for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_MAX)
        begin
            $display("bilinear_map_lookup_test: done, errors");
            $finish;
        end
    end

    initial
    begin
        int send_pct [4] = '{0, 60, 0, 26};
        int recv_pct [4] = '{0, 0, 60, 26};
        signed_cells = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill every entry before the first lookup
        for (int i = 0; i < 16; i++)
        begin
            send_item(MODE_XAXIS, 4'd0, 4'(i), 15'(i*2000), 15'd0, 8'd0, 1'b0, '0);
            send_item(MODE_YAXIS, 4'(i), 4'd0, 15'(i*16), 15'd0, 8'd0, 1'b0, '0);
        end
        for (int i = 0; i < NROW*NCOL; i++)
            send_item(MODE_CELL, 4'(i / NCOL), 4'(i % NCOL), 15'($urandom), 15'($urandom),
                      8'($urandom), 1'b0, '0);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_cfg)
                write_sign_mode(directed_rows[i].wdata[0]);
            else
                send_item(directed_rows[i].mode, directed_rows[i].row, directed_rows[i].col,
                          directed_rows[i].wdata, directed_rows[i].qx, directed_rows[i].qy,
                          directed_rows[i].typed, directed_rows[i].value);
        end

        // random phases, alternating the sign mode between them
        for (int ph = 0; ph < 4; ph++)
        begin
            write_sign_mode(ph[0]);
            send_idle_pct  = send_pct[ph];
            recv_stall_pct = recv_pct[ph];
            load_axes();
            for (int n = 0; n < RAND_ITEMS; n++)
            begin
                // quiet stretch in the middle of each phase
                if (n == RAND_ITEMS / 2)
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                if (n == RAND_ITEMS * 3 / 4)
                begin
                    send_idle_pct  = send_pct[ph];
                    recv_stall_pct = recv_pct[ph];
                end
                random_item();
            end
        end

        // drain and settle
        s_tvalid <= 1'b0;
        while (expected_values.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (mismatches == 0 && expected_values.size() == 0)
            $display("bilinear_map_lookup_test: done, clean");
        else
            $display("bilinear_map_lookup_test: done, errors");
        $finish;
    end

endmodule
